// File: hw/rtl/ints_pkg.sv
// ----------------------------------------------------------------------------
// ints_pkg
// shared types and constants for the integer interchange sorter
// ----------------------------------------------------------------------------
package ints_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W      = $clog2(MAX_ITEMS);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     dropped;
  } result_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     keep;
    logic                     desc;
  } qentry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_GET_I,
    ST_CMP,
    ST_WR_I,
    ST_EM_RD,
    ST_EM_OUT
  } back_state_t;

endpackage

// File: hw/rtl/integer_interchange_sort.sv
// ----------------------------------------------------------------------------
// integer_interchange_sort
// collects a set of signed integers, sorts it by interchange sort, emits it
// ----------------------------------------------------------------------------
// While a set loads, one element is taken per cycle while busy is low; a
// two-entry queue sits between the input side and the element store. The
// element marked last closes the set, after which busy rises once the queue
// is full and stays high through the sort and the emission. The sort
// sequencer makes one compare per cycle on the single-write, single-read
// element store, and then reads out the results. Results come on consecutive
// cycles, each shown for exactly one cycle with result_valid; the receiver
// cannot stall them. At most 64 elements are kept; later ones are dropped
// and flagged on the first result. The direction register is taken from
// cfg_data at any write.
// ----------------------------------------------------------------------------
module integer_interchange_sort (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ints_pkg::item_t   item,
  output logic              result_valid,
  output ints_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import ints_pkg::*;

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  qentry_t wr_entry;
  qentry_t rd_entry;

  ints_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .entry     (wr_entry)
  );

  ints_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  ints_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_entry      (rd_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_out |=> !result_valid)
    else $error("result follows the last transaction of a set");

  a_results_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_out |=> result_valid)
    else $error("gap inside a set of results");

  a_dropped_first_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && $past(result_valid) |-> !result.dropped)
    else $error("dropped flag on a later result");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue read while empty");

endmodule

// File: hw/rtl/ints_fifo.sv
// ----------------------------------------------------------------------------
// ints_fifo
// short queue between the front and back parts of the sorter
// ----------------------------------------------------------------------------
module ints_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ints_pkg::qentry_t wr_entry,
  input  logic             pop,
  output ints_pkg::qentry_t rd_entry,
  output logic             full,
  output logic             empty
);
  import ints_pkg::*;

  qentry_t               slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;

  assign full     = (fill == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (fill == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/ints_front.sv
// ----------------------------------------------------------------------------
// ints_front
// takes input transactions, decides keep or drop, holds the direction register
// ----------------------------------------------------------------------------
module ints_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ints_pkg::item_t   item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              q_full,
  output logic              push,
  output ints_pkg::qentry_t entry
);
  import ints_pkg::*;

  logic             descending;
  logic [CNT_W-1:0] taken;
  logic             room;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign push      = start && !busy;
  assign room      = (taken < CNT_W'(MAX_ITEMS));

  always_comb begin
    entry.value = item.value;
    entry.last  = item.last;
    entry.keep  = room;
    entry.desc  = descending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
      taken      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        descending <= cfg_data;
      end
      if (push) begin
        if (item.last) begin
          taken <= '0;
        end else if (room) begin
          taken <= taken + 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/ints_back.sv
// ----------------------------------------------------------------------------
// ints_back
// element store, interchange sort sequencer and result output register
// ----------------------------------------------------------------------------
module ints_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  ints_pkg::qentry_t q_entry,
  output logic              pop,
  output logic              result_valid,
  output ints_pkg::result_t result
);
  import ints_pkg::*;

  logic signed [DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] rdata;

  back_state_t              state, state_next;
  logic [CNT_W-1:0]         cnt, cnt_next;
  logic                     ovf, ovf_next;
  logic                     desc, desc_next;
  logic [IDX_W-1:0]         i, i_next;
  logic [IDX_W-1:0]         j, j_next;
  logic [IDX_W-1:0]         k, k_next;
  logic signed [DATA_W-1:0] a, a_next;
  result_t                  res_next;
  logic                     res_valid_next;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]         raddr;
  logic                     swap;
  logic [CNT_W-1:0]         top_idx;

  assign top_idx = cnt - CNT_W'(1);
  assign swap    = desc ? (rdata > a) : (a > rdata);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ovf_next       = ovf;
    desc_next      = desc;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    a_next         = a;
    res_next       = result;
    res_valid_next = 1'b0;
    we             = 1'b0;
    waddr          = i;
    wdata          = a;
    raddr          = k;
    pop            = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_entry.keep) begin
            we       = 1'b1;
            waddr    = cnt[IDX_W-1:0];
            wdata    = q_entry.value;
            cnt_next = cnt + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (q_entry.last) begin
            desc_next = q_entry.desc;
            i_next    = '0;
            k_next    = '0;
            if (cnt_next >= CNT_W'(2)) begin
              state_next = ST_RD_I;
            end else begin
              state_next = ST_EM_RD;
            end
          end
        end
      end
      ST_RD_I: begin
        raddr      = i;
        j_next     = i + 1'b1;
        state_next = ST_GET_I;
      end
      ST_GET_I: begin
        a_next     = rdata;
        raddr      = j;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (swap) begin
          we     = 1'b1;
          waddr  = j;
          wdata  = a;
          a_next = rdata;
        end
        if ({1'b0, j} == top_idx) begin
          state_next = ST_WR_I;
        end else begin
          j_next = j + 1'b1;
          raddr  = j + 1'b1;
        end
      end
      ST_WR_I: begin
        we    = 1'b1;
        waddr = i;
        wdata = a;
        if ({1'b0, i} == cnt - CNT_W'(2)) begin
          k_next     = '0;
          state_next = ST_EM_RD;
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_RD_I;
        end
      end
      ST_EM_RD: begin
        raddr      = k;
        state_next = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        res_valid_next        = 1'b1;
        res_next.sorted_value = rdata;
        res_next.last_out     = ({1'b0, k} == top_idx);
        res_next.dropped      = (k == '0) && ovf;
        if ({1'b0, k} == top_idx) begin
          cnt_next   = '0;
          ovf_next   = 1'b0;
          state_next = ST_LOAD;
        end else begin
          k_next = k + 1'b1;
          raddr  = k + 1'b1;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // element store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      cnt          <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      ovf          <= ovf_next;
      result_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    desc   <= desc_next;
    i      <= i_next;
    j      <= j_next;
    k      <= k_next;
    a      <= a_next;
    result <= res_next;
  end

endmodule
